// ===== rtl/core/dpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared types and constants for the depth pixel back-projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package dpb_pkg;

  // Default field widths
  localparam int COORD_BITS_DEF = 12;
  localparam int DEPTH_BITS_DEF = 16;

  // Fixed widths of registers and results
  localparam int CENTER_W = 16;
  localparam int INV_W    = 32;
  localparam int RANGE_W  = 16;
  localparam int COORD_W  = 32;
  localparam int Z_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Pipeline depth: offset, depth product, focal product, round and clamp
  localparam int NUM_STAGES = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_COL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX  = 3'd4;

  typedef struct packed {
    logic [CENTER_W-1:0] center_col_q4;
    logic [CENTER_W-1:0] center_row_q4;
    logic [INV_W-1:0]    inv_focal_col_q32;
    logic [INV_W-1:0]    inv_focal_row_q32;
    logic [RANGE_W-1:0]  range_max_mm;
  } cfg_t;

  // Per-stage load enables of the pipeline
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/dpb_cfg.sv =====
// ----------------------------------------------------------------------------
// dpb_cfg
// Configuration register file, written through an index/data channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dpb_cfg
  import dpb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CENTER_COL: cfg.center_col_q4     <= cfg_data[CENTER_W-1:0];
        CFG_CENTER_ROW: cfg.center_row_q4     <= cfg_data[CENTER_W-1:0];
        CFG_INV_COL:    cfg.inv_focal_col_q32 <= cfg_data[INV_W-1:0];
        CFG_INV_ROW:    cfg.inv_focal_row_q32 <= cfg_data[INV_W-1:0];
        CFG_RANGE_MAX:  cfg.range_max_mm      <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dpb_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpb_pipe_ctrl
// Valid bits and load enables of the pipeline; bubbles collapse under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module dpb_pipe_ctrl
  import dpb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  output pipe_ctrl_t ctrl
);

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] rdy;

  // A stage may load when it is empty or its content moves on
  always_comb begin
    rdy[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NUM_STAGES-1];
  assign ctrl.load = rdy;

endmodule

`default_nettype wire

// ===== rtl/core/dpb_axis.sv =====
// ----------------------------------------------------------------------------
// dpb_axis
// One image axis: offset from the principal point, times depth, times the
// reciprocal focal length, rounded to nearest and clamped to 32 bits signed.
// ----------------------------------------------------------------------------
`default_nettype none

module dpb_axis
  import dpb_pkg::*;
#(
  parameter int PIX_BITS = COORD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire pipe_ctrl_t          ctrl,
  input  wire logic [PIX_BITS-1:0] pix,
  input  wire logic [CENTER_W-1:0] center,
  input  wire logic [Z_W-1:0]      depth,
  input  wire logic [INV_W-1:0]    inv,
  output logic signed [COORD_W-1:0] coord
);

  localparam int SCALED_W = PIX_BITS + 4;
  localparam int MAG_W    = (SCALED_W > CENTER_W) ? SCALED_W : CENTER_W;
  localparam int A_RAW_W  = MAG_W + Z_W;
  localparam int A_W      = (A_RAW_W > INV_W) ? A_RAW_W : INV_W + 1;
  localparam int HI_W     = A_W - INV_W;
  localparam int Q_W      = HI_W + INV_W + 1;

  logic [MAG_W-1:0] scaled;
  logic [MAG_W-1:0] ctr;
  logic             neg_now;

  logic [MAG_W-1:0]          mag1;
  logic                      neg1;
  logic [A_W-1:0]            a2;
  logic                      neg2;
  logic [HI_W+INV_W-1:0]     hi_prod3;
  logic [2*INV_W-1:0]        lo_prod3;
  logic                      neg3;
  logic [Q_W-1:0]            q;
  logic                      over;
  logic [COORD_W-1:0]        coord_next;

  assign scaled  = MAG_W'({pix, 4'b0000});
  assign ctr     = MAG_W'(center);
  assign neg_now = scaled < ctr;

  // Rounding: adding one half to the low product carries out exactly its bit 31
  always_comb begin
    q = Q_W'(hi_prod3) + Q_W'(lo_prod3[2*INV_W-1:INV_W]) + Q_W'(lo_prod3[INV_W-1]);
    over = q[Q_W-1:COORD_W-1] != '0;
    if (neg3) begin
      coord_next = over ? {1'b1, {(COORD_W-1){1'b0}}} : COORD_W'(0) - q[COORD_W-1:0];
    end else begin
      coord_next = over ? {1'b0, {(COORD_W-1){1'b1}}} : q[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      mag1 <= neg_now ? ctr - scaled : scaled - ctr;
      neg1 <= neg_now;
    end
    if (ctrl.load[1]) begin
      a2   <= A_W'(mag1) * A_W'(depth);
      neg2 <= neg1;
    end
    if (ctrl.load[2]) begin
      hi_prod3 <= (HI_W + INV_W)'(a2[A_W-1:INV_W]) * (HI_W + INV_W)'(inv);
      lo_prod3 <= (2 * INV_W)'(a2[INV_W-1:0]) * (2 * INV_W)'(inv);
      neg3     <= neg2;
    end
    if (ctrl.load[3]) begin
      coord <= coord_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/depth_pixel_backprojection.sv =====
// Pipeline stages in order: offset, depth product, focal product,
// round and clamp; each stage is registered.
// Throughput: one item per cycle; a stall backs up through the stages and
// empty stages are filled while the output waits.
// Reset: rst clears the stage valid bits and all configuration registers.
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// Pinhole back-projection of depth pixels into 3D points.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pixel_backprojection
  import dpb_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DEPTH_BITS = DEPTH_BITS_DEF,
  localparam int IN_W = ((2 * COORD_BITS + DEPTH_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // pixel_col, pixel_row, depth_mm (from bit 0 up), zero padded
  input  wire logic [IN_W-1:0]       s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // point_x, point_y, point_z (from bit 0 up)
  output logic [2*COORD_W+Z_W-1:0]   m_tdata,
  // point_valid
  output logic                       m_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  pipe_ctrl_t ctrl;

  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;
  logic [Z_W-1:0]        depth_in;
  logic [Z_W-1:0]        depth_sel;

  logic [Z_W-1:0] depth1, depth2, depth3, depth4;

  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;

  assign pixel_col = s_tdata[COORD_BITS-1:0];
  assign pixel_row = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign depth_in  = Z_W'(s_tdata[2*COORD_BITS+DEPTH_BITS-1:2*COORD_BITS]);

  // Missing depth takes the range limit; a zero result flags the point invalid
  // and drives X, Y and Z to zero through the products
  assign depth_sel = (depth_in == '0) ? cfg.range_max_mm : depth_in;

  dpb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpb_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .ctrl      (ctrl)
  );

  dpb_axis #(
    .PIX_BITS (COORD_BITS)
  ) u_axis_col (
    .clk    (clk),
    .ctrl   (ctrl),
    .pix    (pixel_col),
    .center (cfg.center_col_q4),
    .depth  (depth1),
    .inv    (cfg.inv_focal_col_q32),
    .coord  (point_x)
  );

  dpb_axis #(
    .PIX_BITS (COORD_BITS)
  ) u_axis_row (
    .clk    (clk),
    .ctrl   (ctrl),
    .pix    (pixel_row),
    .center (cfg.center_row_q4),
    .depth  (depth1),
    .inv    (cfg.inv_focal_row_q32),
    .coord  (point_y)
  );

  // Carry the depth alongside the axis stages
  always_ff @(posedge clk) begin
    if (ctrl.load[0]) depth1 <= depth_sel;
    if (ctrl.load[1]) depth2 <= depth1;
    if (ctrl.load[2]) depth3 <= depth2;
    if (ctrl.load[3]) depth4 <= depth3;
  end

  assign m_tdata = {depth4, point_y, point_x};
  assign m_tuser = depth4 != '0;

endmodule

`default_nettype wire
